@@ src/segment_segment_closest_points_assert.svh @@
// Assertion macros for the closest-points block.
`ifndef SEGMENT_SEGMENT_CLOSEST_POINTS_ASSERT_SVH
`define SEGMENT_SEGMENT_CLOSEST_POINTS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssc assertion failed");
`define SSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssc assertion failed");
`else
`define SSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/ssc_pkg.sv @@
// Types and constants shared by the closest-points block.
`timescale 1ns / 1ps
package ssc_pkg;

  localparam int FRAC_BITS = 16;
  localparam logic [FRAC_BITS:0] ONE_Q16 = 17'h10000;

  typedef enum logic [2:0] {
    CASE_BOTH_PT  = 3'd0,
    CASE_SEG1_PT  = 3'd1,
    CASE_SEG2_PT  = 3'd2,
    CASE_PARALLEL = 3'd3,
    CASE_GENERAL  = 3'd4
  } ssc_case_e;

  typedef struct packed {
    logic signed [15:0] seg1_start_x;
    logic signed [15:0] seg1_start_y;
    logic signed [15:0] seg1_start_z;
    logic signed [15:0] seg1_end_x;
    logic signed [15:0] seg1_end_y;
    logic signed [15:0] seg1_end_z;
    logic signed [15:0] seg2_start_x;
    logic signed [15:0] seg2_start_y;
    logic signed [15:0] seg2_start_z;
    logic signed [15:0] seg2_end_x;
    logic signed [15:0] seg2_end_y;
    logic signed [15:0] seg2_end_z;
  } ssc_in_t;

  typedef struct packed {
    logic signed [15:0] near1_x;
    logic signed [15:0] near1_y;
    logic signed [15:0] near1_z;
    logic signed [15:0] near2_x;
    logic signed [15:0] near2_y;
    logic signed [15:0] near2_z;
    logic [16:0]        param_s;
    logic [16:0]        param_t;
    logic [2:0]         case_taken;
  } ssc_out_t;

endpackage

@@ src/segment_segment_closest_points.sv @@
// Closest points between two 3D segments, fully pipelined.
//
//  channel | signals                           | handshake
//  in      | in_valid_i/in_ready_o, in_data_i  | valid/ready, beat on both high
//  out     | out_valid_o/out_ready_i, out_data_o | valid/ready, beat on both high
//  cfg     | cfg_we_i, cfg_wdata_i             | write on we, no wait
//
// One beat enters per cycle while the output is not stalled; the s and t
// dividers, 17 stages each, run in series (the t quotient needs s).
// Reset clears the valid bits and sets the threshold to 1.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps
`include "segment_segment_closest_points_assert.svh"
module segment_segment_closest_points (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ssc_pkg::ssc_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ssc_pkg::ssc_out_t out_data_o,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i
);

  localparam int FB     = ssc_pkg::FRAC_BITS;
  localparam int DivLat = FB + 1;
  localparam int NStg   = 5 + DivLat + 2 + DivLat + 3;

  typedef struct packed {
    logic [2:0][15:0]   p1;
    logic [2:0][15:0]   p2;
    logic [2:0][16:0]   d1;
    logic [2:0][16:0]   d2;
    logic signed [34:0] b;
    logic signed [34:0] f;
    logic [33:0]        e;
    ssc_pkg::ssc_case_e kase;
  } sb1_t;

  typedef struct packed {
    logic [2:0][15:0]   p1;
    logic [2:0][15:0]   p2;
    logic [2:0][16:0]   d1;
    logic [2:0][16:0]   d2;
    ssc_pkg::ssc_case_e kase;
    logic [FB:0]        s_gen;
    logic [FB:0]        q_c;
    logic [FB:0]        q_bc;
    logic [FB:0]        q_f;
    logic               lo;
    logic               hi;
  } sb2_t;

  logic              adv;
  logic [NStg-1:0]   vld_q;
  logic [15:0]       thr_q;
  logic [15:0]       te_w;

  assign adv         = !vld_q[NStg-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[NStg-1];
  assign te_w        = (thr_q == 16'd0) ? 16'd1 : thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      thr_q <= 16'd1;
    end else begin
      if (adv) vld_q <= {vld_q[NStg-2:0], in_valid_i};
      if (cfg_we_i) thr_q <= cfg_wdata_i;
    end
  end

  // input unpack
  logic signed [15:0] in_p1 [3], in_q1 [3], in_p2 [3], in_q2 [3];
  always_comb begin
    in_p1[0] = in_data_i.seg1_start_x;  in_p1[1] = in_data_i.seg1_start_y;
    in_p1[2] = in_data_i.seg1_start_z;
    in_q1[0] = in_data_i.seg1_end_x;    in_q1[1] = in_data_i.seg1_end_y;
    in_q1[2] = in_data_i.seg1_end_z;
    in_p2[0] = in_data_i.seg2_start_x;  in_p2[1] = in_data_i.seg2_start_y;
    in_p2[2] = in_data_i.seg2_start_z;
    in_q2[0] = in_data_i.seg2_end_x;    in_q2[1] = in_data_i.seg2_end_y;
    in_q2[2] = in_data_i.seg2_end_z;
  end

  // S1: differences
  logic signed [15:0] s1_p1_q [3], s1_p2_q [3];
  logic signed [16:0] s1_d1_q [3], s1_d2_q [3], s1_r_q [3];
  // S2: products
  logic signed [15:0] s2_p1_q [3], s2_p2_q [3];
  logic signed [16:0] s2_d1_q [3], s2_d2_q [3];
  logic signed [33:0] s2_aa_q [3], s2_ee_q [3], s2_bb_q [3], s2_cc_q [3], s2_ff_q [3];
  // S3: dot products
  logic signed [15:0] s3_p1_q [3], s3_p2_q [3];
  logic signed [16:0] s3_d1_q [3], s3_d2_q [3];
  logic [33:0]        s3_a_q, s3_e_q;
  logic signed [34:0] s3_b_q, s3_c_q, s3_f_q;
  logic signed [35:0] sum_a, sum_e, sum_b, sum_c, sum_f;
  // S4: wide products
  logic signed [15:0] s4_p1_q [3], s4_p2_q [3];
  logic signed [16:0] s4_d1_q [3], s4_d2_q [3];
  logic [33:0]        s4_a_q, s4_e_q;
  logic signed [34:0] s4_b_q, s4_c_q, s4_f_q;
  logic [67:0]        s4_ae_q;
  logic signed [69:0] s4_bb_q, s4_bf_q, s4_ce_q;
  // S5: case and divider operands
  logic signed [69:0] denom_w;
  logic signed [70:0] nums_w;
  logic               par_w;
  ssc_pkg::ssc_case_e kase_w;
  logic [67:0]        s5_denom_q;
  logic signed [70:0] s5_nums_q;
  logic signed [35:0] s5_negc_q, s5_bmc_q;
  logic signed [34:0] s5_f_q;
  logic [33:0]        s5_a_q;
  sb1_t               s5_sb_q;
  sb1_t               sb1_q [DivLat];

  always_comb begin
    sum_a = 36'(s2_aa_q[0]) + 36'(s2_aa_q[1]) + 36'(s2_aa_q[2]);
    sum_e = 36'(s2_ee_q[0]) + 36'(s2_ee_q[1]) + 36'(s2_ee_q[2]);
    sum_b = 36'(s2_bb_q[0]) + 36'(s2_bb_q[1]) + 36'(s2_bb_q[2]);
    sum_c = 36'(s2_cc_q[0]) + 36'(s2_cc_q[1]) + 36'(s2_cc_q[2]);
    sum_f = 36'(s2_ff_q[0]) + 36'(s2_ff_q[1]) + 36'(s2_ff_q[2]);
    denom_w = $signed({2'b00, s4_ae_q}) - s4_bb_q;
    nums_w  = 71'(s4_bf_q) - 71'(s4_ce_q);
    par_w   = (denom_w[67:0] <= 68'({te_w, 16'h0000}));
    if (s4_a_q < 34'(te_w) && s4_e_q < 34'(te_w)) kase_w = ssc_pkg::CASE_BOTH_PT;
    else if (s4_a_q < 34'(te_w))                   kase_w = ssc_pkg::CASE_SEG1_PT;
    else if (s4_e_q < 34'(te_w))                   kase_w = ssc_pkg::CASE_SEG2_PT;
    else if (par_w)                                kase_w = ssc_pkg::CASE_PARALLEL;
    else                                           kase_w = ssc_pkg::CASE_GENERAL;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_p1_q[i] <= in_p1[i];
        s1_p2_q[i] <= in_p2[i];
        s1_d1_q[i] <= 17'(in_q1[i]) - 17'(in_p1[i]);
        s1_d2_q[i] <= 17'(in_q2[i]) - 17'(in_p2[i]);
        s1_r_q[i]  <= 17'(in_p1[i]) - 17'(in_p2[i]);
        s2_p1_q[i] <= s1_p1_q[i];  s2_p2_q[i] <= s1_p2_q[i];
        s2_d1_q[i] <= s1_d1_q[i];  s2_d2_q[i] <= s1_d2_q[i];
        s2_aa_q[i] <= s1_d1_q[i] * s1_d1_q[i];
        s2_ee_q[i] <= s1_d2_q[i] * s1_d2_q[i];
        s2_bb_q[i] <= s1_d1_q[i] * s1_d2_q[i];
        s2_cc_q[i] <= s1_d1_q[i] * s1_r_q[i];
        s2_ff_q[i] <= s1_d2_q[i] * s1_r_q[i];
        s3_p1_q[i] <= s2_p1_q[i];  s3_p2_q[i] <= s2_p2_q[i];
        s3_d1_q[i] <= s2_d1_q[i];  s3_d2_q[i] <= s2_d2_q[i];
        s4_p1_q[i] <= s3_p1_q[i];  s4_p2_q[i] <= s3_p2_q[i];
        s4_d1_q[i] <= s3_d1_q[i];  s4_d2_q[i] <= s3_d2_q[i];
        s5_sb_q.p1[i] <= s4_p1_q[i];  s5_sb_q.p2[i] <= s4_p2_q[i];
        s5_sb_q.d1[i] <= s4_d1_q[i];  s5_sb_q.d2[i] <= s4_d2_q[i];
      end
      s3_a_q <= sum_a[33:0];
      s3_e_q <= sum_e[33:0];
      s3_b_q <= sum_b[34:0];
      s3_c_q <= sum_c[34:0];
      s3_f_q <= sum_f[34:0];
      s4_a_q <= s3_a_q;  s4_e_q <= s3_e_q;
      s4_b_q <= s3_b_q;  s4_c_q <= s3_c_q;  s4_f_q <= s3_f_q;
      s4_ae_q <= s3_a_q * s3_e_q;
      s4_bb_q <= s3_b_q * s3_b_q;
      s4_bf_q <= s3_b_q * s3_f_q;
      s4_ce_q <= $signed({1'b0, s3_e_q}) * s3_c_q;
      s5_denom_q <= denom_w[67:0];
      s5_nums_q  <= nums_w;
      s5_negc_q  <= -36'(s4_c_q);
      s5_bmc_q   <= 36'(s4_b_q) - 36'(s4_c_q);
      s5_f_q     <= s4_f_q;
      s5_a_q     <= s4_a_q;
      s5_sb_q.b    <= s4_b_q;
      s5_sb_q.f    <= s4_f_q;
      s5_sb_q.e    <= s4_e_q;
      s5_sb_q.kase <= kase_w;
      sb1_q[0] <= s5_sb_q;
      for (int k = 1; k < DivLat; k++) sb1_q[k] <= sb1_q[k-1];
    end
  end

  logic [FB:0] q_s, q_c, q_bc, q_f, q_t;

  ssc_div #(.NW(71), .DW(68)) u_div_s (
    .clk_i(clk_i), .en_i(adv), .num_i(s5_nums_q), .den_i(s5_denom_q), .quo_o(q_s));
  ssc_div #(.NW(36), .DW(34)) u_div_c (
    .clk_i(clk_i), .en_i(adv), .num_i(s5_negc_q), .den_i(s5_a_q), .quo_o(q_c));
  ssc_div #(.NW(36), .DW(34)) u_div_bc (
    .clk_i(clk_i), .en_i(adv), .num_i(s5_bmc_q), .den_i(s5_a_q), .quo_o(q_bc));
  ssc_div #(.NW(35), .DW(34)) u_div_f (
    .clk_i(clk_i), .en_i(adv), .num_i(s5_f_q), .den_i(s5_sb_q.e), .quo_o(q_f));

  // T1: b*s, T2: t numerator and range flags
  sb1_t               t1_sb_q;
  logic [FB:0]        t1_sgen_q, t1_qc_q, t1_qbc_q, t1_qf_q;
  logic signed [52:0] t1_prod_q;
  logic [FB:0]        sgen_w;
  logic signed [53:0] tn_w;
  logic [50:0]        eh_w;
  sb2_t               t2_sb_q;
  logic signed [53:0] t2_tn_q;
  logic [49:0]        t2_eden_q;
  sb2_t               sb2_q [DivLat];

  always_comb begin
    sgen_w = (sb1_q[DivLat-1].kase == ssc_pkg::CASE_GENERAL) ? q_s : '0;
    tn_w   = 54'(t1_prod_q) + (54'(t1_sb_q.f) <<< FB);
    eh_w   = {1'b0, t1_sb_q.e, 16'h0000} + 51'(t1_sb_q.e);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_sb_q   <= sb1_q[DivLat-1];
      t1_sgen_q <= sgen_w;
      t1_qc_q   <= q_c;
      t1_qbc_q  <= q_bc;
      t1_qf_q   <= q_f;
      t1_prod_q <= sb1_q[DivLat-1].b * $signed({1'b0, sgen_w});
      t2_sb_q.p1    <= t1_sb_q.p1;
      t2_sb_q.p2    <= t1_sb_q.p2;
      t2_sb_q.d1    <= t1_sb_q.d1;
      t2_sb_q.d2    <= t1_sb_q.d2;
      t2_sb_q.kase  <= t1_sb_q.kase;
      t2_sb_q.s_gen <= t1_sgen_q;
      t2_sb_q.q_c   <= t1_qc_q;
      t2_sb_q.q_bc  <= t1_qbc_q;
      t2_sb_q.q_f   <= t1_qf_q;
      t2_sb_q.lo    <= ((tn_w + $signed({20'h0, t1_sb_q.e})) <= 0);
      t2_sb_q.hi    <= (tn_w >= $signed({3'b000, eh_w}));
      t2_tn_q       <= tn_w;
      t2_eden_q     <= {t1_sb_q.e, 16'h0000};
      sb2_q[0] <= t2_sb_q;
      for (int k = 1; k < DivLat; k++) sb2_q[k] <= sb2_q[k-1];
    end
  end

  ssc_div #(.NW(54), .DW(50)) u_div_t (
    .clk_i(clk_i), .en_i(adv), .num_i(t2_tn_q), .den_i(t2_eden_q), .quo_o(q_t));

  // M1: pick s and t, M2: scale directions, OUT: add to start points
  sb2_t               m_sb;
  logic [FB:0]        s_sel, t_sel;
  logic [FB:0]        m1_s_q, m1_t_q, m2_s_q, m2_t_q;
  logic [2:0]         m1_kase_q, m2_kase_q;
  logic signed [15:0] m1_p1_q [3], m1_p2_q [3], m2_p1_q [3], m2_p2_q [3];
  logic signed [16:0] m1_d1_q [3], m1_d2_q [3];
  logic signed [34:0] m2_pr1_q [3], m2_pr2_q [3];
  logic signed [18:0] mv1_w [3], mv2_w [3];
  logic signed [15:0] n1_w [3], n2_w [3];
  ssc_pkg::ssc_out_t  out_q;

  assign m_sb = sb2_q[DivLat-1];

  always_comb begin
    s_sel = '0;
    t_sel = '0;
    case (m_sb.kase)
      ssc_pkg::CASE_BOTH_PT: begin
        s_sel = '0;
        t_sel = '0;
      end
      ssc_pkg::CASE_SEG1_PT: begin
        t_sel = m_sb.q_f;
      end
      ssc_pkg::CASE_SEG2_PT: begin
        s_sel = m_sb.q_c;
      end
      ssc_pkg::CASE_PARALLEL, ssc_pkg::CASE_GENERAL: begin
        if (m_sb.lo) begin
          s_sel = m_sb.q_c;
        end else if (m_sb.hi) begin
          s_sel = m_sb.q_bc;
          t_sel = ssc_pkg::ONE_Q16;
        end else begin
          s_sel = m_sb.s_gen;
          t_sel = q_t;
        end
      end
      default: begin
        s_sel = '0;
        t_sel = '0;
      end
    endcase
    // truncate toward zero
    for (int i = 0; i < 3; i++) begin
      mv1_w[i] = (m2_pr1_q[i] < 0) ? 19'((m2_pr1_q[i] + 35'sd65535) >>> FB)
                                   : 19'(m2_pr1_q[i] >>> FB);
      mv2_w[i] = (m2_pr2_q[i] < 0) ? 19'((m2_pr2_q[i] + 35'sd65535) >>> FB)
                                   : 19'(m2_pr2_q[i] >>> FB);
      n1_w[i] = 16'(19'(m2_p1_q[i]) + mv1_w[i]);
      n2_w[i] = 16'(19'(m2_p2_q[i]) + mv2_w[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_s_q    <= s_sel;
      m1_t_q    <= t_sel;
      m1_kase_q <= m_sb.kase;
      m2_s_q    <= m1_s_q;
      m2_t_q    <= m1_t_q;
      m2_kase_q <= m1_kase_q;
      for (int i = 0; i < 3; i++) begin
        m1_p1_q[i]  <= m_sb.p1[i];
        m1_p2_q[i]  <= m_sb.p2[i];
        m1_d1_q[i]  <= m_sb.d1[i];
        m1_d2_q[i]  <= m_sb.d2[i];
        m2_p1_q[i]  <= m1_p1_q[i];
        m2_p2_q[i]  <= m1_p2_q[i];
        m2_pr1_q[i] <= m1_d1_q[i] * $signed({1'b0, m1_s_q});
        m2_pr2_q[i] <= m1_d2_q[i] * $signed({1'b0, m1_t_q});
      end
      out_q.near1_x    <= n1_w[0];
      out_q.near1_y    <= n1_w[1];
      out_q.near1_z    <= n1_w[2];
      out_q.near2_x    <= n2_w[0];
      out_q.near2_y    <= n2_w[1];
      out_q.near2_z    <= n2_w[2];
      out_q.param_s    <= m2_s_q;
      out_q.param_t    <= m2_t_q;
      out_q.case_taken <= m2_kase_q;
    end
  end

  assign out_data_o = out_q;

  `SSC_ASSERT_IMP(a_both_zero, clk_i, rst_ni,
    out_valid_o && out_data_o.case_taken == ssc_pkg::CASE_BOTH_PT,
    out_data_o.param_s == '0 && out_data_o.param_t == '0)
  `SSC_ASSERT_IMP(a_seg1_s_zero, clk_i, rst_ni,
    out_valid_o && out_data_o.case_taken == ssc_pkg::CASE_SEG1_PT,
    out_data_o.param_s == '0)
  `SSC_ASSERT_IMP(a_param_range, clk_i, rst_ni, out_valid_o,
    out_data_o.param_s <= ssc_pkg::ONE_Q16 && out_data_o.param_t <= ssc_pkg::ONE_Q16)
  `SSC_ASSERT_NXT(a_last_stage_moves, clk_i, rst_ni, adv && vld_q[NStg-2], out_valid_o)

endmodule

@@ src/ssc_div.sv @@
// Pipelined restoring divider giving a ratio clamped to [0,1] in Q1.16.
`timescale 1ns / 1ps
module ssc_div #(
  parameter int NW = 36,
  parameter int DW = 34
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [NW-1:0]          num_i,
  input  logic [DW-1:0]                 den_i,
  output logic [ssc_pkg::FRAC_BITS:0]   quo_o
);

  localparam int FB = ssc_pkg::FRAC_BITS;
  localparam int CW = ((NW > DW) ? NW : DW) + 1;

  logic signed [CW-1:0] num_x, den_x;
  logic                 zero_w, one_w;

  logic [DW-1:0] rem_q [FB+1];
  logic [DW-1:0] den_q [FB+1];
  logic [FB-1:0] quo_q [FB+1];
  logic          zero_q [FB+1];
  logic          one_q [FB+1];

  logic [DW:0] sh_w [FB];
  logic [DW:0] dif_w [FB];
  logic        ge_w [FB];

  assign num_x  = CW'(num_i);
  assign den_x  = $signed({{(CW-DW){1'b0}}, den_i});
  assign zero_w = (num_x <= 0);
  assign one_w  = (num_x >= den_x);

  always_comb begin
    for (int k = 0; k < FB; k++) begin
      sh_w[k]  = {rem_q[k], 1'b0};
      dif_w[k] = sh_w[k] - {1'b0, den_q[k]};
      ge_w[k]  = (sh_w[k] >= {1'b0, den_q[k]});
    end
  end

  // one quotient bit per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_x[DW-1:0];
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      zero_q[0] <= zero_w;
      one_q[0]  <= one_w;
      for (int k = 1; k <= FB; k++) begin
        rem_q[k]  <= ge_w[k-1] ? dif_w[k-1][DW-1:0] : sh_w[k-1][DW-1:0];
        den_q[k]  <= den_q[k-1];
        quo_q[k]  <= {quo_q[k-1][FB-2:0], ge_w[k-1]};
        zero_q[k] <= zero_q[k-1];
        one_q[k]  <= one_q[k-1];
      end
    end
  end

  assign quo_o = one_q[FB]  ? ssc_pkg::ONE_Q16 :
                 zero_q[FB] ? '0 : {1'b0, quo_q[FB]};

endmodule

@@ tb/segment_segment_closest_points_tb.sv @@
// Self-checking testbench for the 3D segment closest-points block.
`timescale 1ns / 1ps
module segment_segment_closest_points_tb;

  localparam int LATENCY = 44;
  localparam int WATCHDOG_LIMIT = 20000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  ssc_pkg::ssc_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ssc_pkg::ssc_out_t out_data_o;
  logic     cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  ssc_pkg::ssc_out_t expected_points[$];
  logic [15:0] threshold_q;
  int         send_idle_pct, recv_idle_pct;
  int         error_count, beats_in, beats_out, idle_cycles;
  int         case_hits[5];

  always #10 clk_i = ~clk_i;

  segment_segment_closest_points dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_wdata_i
  );

  // Clamp n/d to [0,1] in Q1.16, d > 0.
  function automatic logic [16:0] clamped_fraction(logic signed [127:0] n,
                                                   logic signed [127:0] d);
    if (n <= 0) return 17'd0;
    if (n >= d) return ssc_pkg::ONE_Q16;
    return 17'((n * 65536) / d);
  endfunction

  function automatic logic signed [15:0] point_along(logic signed [63:0] p,
      logic signed [63:0] d, logic [16:0] frac);
    logic signed [63:0] prod;
    prod = d * $signed({47'd0, frac});
    // SV division truncates toward zero
    return 16'(p + prod / 65536);
  endfunction

  function automatic ssc_pkg::ssc_out_t closest_points(ssc_pkg::ssc_in_t it,
                                                       logic [15:0] thr);
    logic signed [63:0] p1[3], p2[3], d1[3], d2[3], r[3];
    logic signed [63:0] a, e, b, c, f, te, tn;
    logic signed [127:0] denom;
    logic [16:0] s, t;
    ssc_pkg::ssc_case_e kase;
    ssc_pkg::ssc_out_t res;
    p1 = '{it.seg1_start_x, it.seg1_start_y, it.seg1_start_z};
    p2 = '{it.seg2_start_x, it.seg2_start_y, it.seg2_start_z};
    d1 = '{it.seg1_end_x - p1[0], it.seg1_end_y - p1[1], it.seg1_end_z - p1[2]};
    d2 = '{it.seg2_end_x - p2[0], it.seg2_end_y - p2[1], it.seg2_end_z - p2[2]};
    a = 0; e = 0; b = 0; c = 0; f = 0; s = 0; t = 0;
    for (int i = 0; i < 3; i++) begin
      r[i] = p1[i] - p2[i];
      a += d1[i] * d1[i];
      e += d2[i] * d2[i];
      b += d1[i] * d2[i];
      c += d1[i] * r[i];
      f += d2[i] * r[i];
    end
    te = (thr == 0) ? 64'sd1 : $signed({48'd0, thr});
    if (a < te && e < te) begin
      kase = ssc_pkg::CASE_BOTH_PT;
    end else if (a < te) begin
      kase = ssc_pkg::CASE_SEG1_PT;
      t = clamped_fraction(f, e);
    end else if (e < te) begin
      kase = ssc_pkg::CASE_SEG2_PT;
      s = clamped_fraction(-c, a);
    end else begin
      denom = 128'(a) * 128'(e) - 128'(b) * 128'(b);
      if (denom > 128'(te) * 65536) begin
        kase = ssc_pkg::CASE_GENERAL;
        s = clamped_fraction(128'(b) * 128'(f) - 128'(c) * 128'(e), denom);
      end else begin
        kase = ssc_pkg::CASE_PARALLEL;
      end
      tn = b * $signed({47'd0, s}) + f * 65536;
      if (tn <= -e) begin
        t = 0;
        s = clamped_fraction(-c, a);
      end else if (tn >= 65537 * e) begin
        t = ssc_pkg::ONE_Q16;
        s = clamped_fraction(b - c, a);
      end else begin
        t = (tn < 0) ? 17'd0 : 17'(tn / e);
      end
    end
    res.near1_x = point_along(p1[0], d1[0], s);
    res.near1_y = point_along(p1[1], d1[1], s);
    res.near1_z = point_along(p1[2], d1[2], s);
    res.near2_x = point_along(p2[0], d2[0], t);
    res.near2_y = point_along(p2[1], d2[1], t);
    res.near2_z = point_along(p2[2], d2[2], t);
    res.param_s = s;
    res.param_t = t;
    res.case_taken = kase;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch beat %0d %s: got %h want %h", beats_out, what, got, want);
    error_count++;
  endtask

  // Hold valid across the accepting edge; drop it only while idling.
  task automatic send_pair(ssc_pkg::ssc_in_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    expected_points.push_back(closest_points(it, threshold_q));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_in++;
  endtask

  // Sink side: drive ready and compare each beat with the oldest prediction.
  always @(posedge clk_i) begin
    ssc_pkg::ssc_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        beats_out++;
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected beat", 32'd0, 32'd0);
        end else begin
          want = expected_points.pop_front();
          case_hits[want.case_taken]++;
          if (out_data_o.near1_x !== want.near1_x)
            report_mismatch("near1_x", 32'(out_data_o.near1_x), 32'(want.near1_x));
          if (out_data_o.near1_y !== want.near1_y)
            report_mismatch("near1_y", 32'(out_data_o.near1_y), 32'(want.near1_y));
          if (out_data_o.near1_z !== want.near1_z)
            report_mismatch("near1_z", 32'(out_data_o.near1_z), 32'(want.near1_z));
          if (out_data_o.near2_x !== want.near2_x)
            report_mismatch("near2_x", 32'(out_data_o.near2_x), 32'(want.near2_x));
          if (out_data_o.near2_y !== want.near2_y)
            report_mismatch("near2_y", 32'(out_data_o.near2_y), 32'(want.near2_y));
          if (out_data_o.near2_z !== want.near2_z)
            report_mismatch("near2_z", 32'(out_data_o.near2_z), 32'(want.near2_z));
          if (out_data_o.param_s !== want.param_s)
            report_mismatch("param_s", 32'(out_data_o.param_s), 32'(want.param_s));
          if (out_data_o.param_t !== want.param_t)
            report_mismatch("param_t", 32'(out_data_o.param_t), 32'(want.param_t));
          if (out_data_o.case_taken !== want.case_taken)
            report_mismatch("case_taken", 32'(out_data_o.case_taken),
                            32'(want.case_taken));
        end
      end
      out_ready_i <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress");
      $display("segment_segment_closest_points_tb: errors");
      $finish;
    end
  end

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [15:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    threshold_q = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] coord();
    case ($urandom_range(5))
      0:       return 16'h8000 + 16'($urandom_range(3));
      1:       return 16'h7FFF - 16'($urandom_range(3));
      2:       return 16'($signed($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ssc_pkg::ssc_in_t random_pair();
    ssc_pkg::ssc_in_t it;
    logic [15:0] v[12];
    for (int i = 0; i < 12; i++) v[i] = coord();
    case ($urandom_range(9))
      0: for (int i = 0; i < 3; i++) v[3 + i] = v[i] + 16'($urandom_range(2));
      1: for (int i = 0; i < 3; i++) v[9 + i] = v[6 + i] + 16'($urandom_range(2));
      2: for (int i = 0; i < 3; i++) begin
        v[3 + i] = v[i];
        v[9 + i] = v[6 + i];
      end
      3: for (int i = 0; i < 3; i++) begin
        // parallel: segment two is a shifted copy of segment one
        v[i] = 16'($signed($urandom_range(8000)) - 4000);
        v[3 + i] = 16'($signed($urandom_range(8000)) - 4000);
        v[6 + i] = v[i] + 16'($urandom_range(600));
        v[9 + i] = v[3 + i] - v[i] + v[6 + i];
      end
      default: ;
    endcase
    it = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
    return it;
  endfunction

  task automatic test_directed();
    ssc_pkg::ssc_in_t it;
    it = '0;
    send_pair(it);
    it = {12{16'h7FFF}};
    send_pair(it);
    it = {12{16'h8000}};
    send_pair(it);
    it = {16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
          16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    send_pair(it);
    // seg1 point, seg2 point
    it = {16'h0100, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0,
          16'h0, 16'hFF00, 16'h0, 16'h0, 16'h0100, 16'h0};
    send_pair(it);
    it = {16'h0, 16'hFF00, 16'h0, 16'h0, 16'h0100, 16'h0,
          16'h0100, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0};
    send_pair(it);
    // parallel, overlapping and disjoint
    it = {16'h0, 16'h0, 16'h0, 16'h0400, 16'h0, 16'h0,
          16'h0100, 16'h0100, 16'h0, 16'h0500, 16'h0100, 16'h0};
    send_pair(it);
    it = {16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0,
          16'hF000, 16'h0100, 16'h0, 16'hE000, 16'h0100, 16'h0};
    send_pair(it);
    // crossing, then t below 0 and above 1
    it = {16'hFF00, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0,
          16'h0, 16'hFF00, 16'h0100, 16'h0, 16'h0100, 16'h0100};
    send_pair(it);
    it = {16'hFF00, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0,
          16'h0, 16'h0200, 16'h0100, 16'h0, 16'h0400, 16'h0100};
    send_pair(it);
    it = {16'hFF00, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0,
          16'h0, 16'hFC00, 16'h0100, 16'h0, 16'hFE00, 16'h0100};
    send_pair(it);
    for (int i = 0; i < 12; i++) begin
      it = '0;
      it[16 * i +: 16] = (i % 2) ? 16'h7FFF : 16'h8000;
      send_pair(it);
    end
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_pair(random_pair());
  endtask

  task automatic test_thresholds();
    logic [15:0] settings[4] = '{16'd0, 16'hFFFF, 16'd300, 16'd1};
    foreach (settings[k]) begin
      write_threshold(settings[k]);
      test_directed();
      test_random(60);
    end
  endtask

  initial begin
    threshold_q = 16'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_directed();
    send_idle_pct = 12;
    recv_idle_pct = 75;
    test_random(350);
    send_idle_pct = 75;
    recv_idle_pct = 12;
    test_random(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(250);
    test_thresholds();
    drain();
    $display("%0d pairs in, %0d out; cases both/seg1/seg2/parallel/general %0d/%0d/%0d/%0d/%0d",
             beats_in, beats_out, case_hits[0], case_hits[1], case_hits[2],
             case_hits[3], case_hits[4]);
    $display("threshold 1 under three stall patterns, then thresholds 0, 65535, 300, 1");
    if (error_count == 0) begin
      $display("segment_segment_closest_points_tb: clean");
    end else begin
      $display("segment_segment_closest_points_tb: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/ssc_pkg.sv
src/ssc_div.sv
src/segment_segment_closest_points.sv
tb/segment_segment_closest_points_tb.sv
